>>> src/im2c_pkg.sv
// Shared types and constants for the im2col unfold core.
// No dependencies; imported by every module of the block but im2c_ram.
`timescale 1ns / 1ps
`default_nettype none

package im2c_pkg;

  // Build-time defaults for the top-level parameters
  localparam int unsigned IMAGE_WORDS_DEF = 4096;
  localparam int unsigned CHANNELS_DEF    = 4;

  // Field widths
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned DIM_W    = 7;
  localparam int unsigned KER_W    = 5;
  localparam int unsigned PAD_W    = 4;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned CH_IDX_W = 6;   // channel index, up to 64 channels

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_ROWS     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_COLS     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ROWS    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COLS    = 4'd7;

  // Opcodes carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Shared multiply-add unit: q = a * b + c
  localparam int unsigned MAC_A_W = 13;
  localparam int unsigned MAC_B_W = DIM_W;
  localparam int unsigned MAC_Q_W = 21;

  typedef struct packed {
    logic [DIM_W-1:0]  image_height;
    logic [DIM_W-1:0]  image_width;
    logic [KER_W-1:0]  kernel_rows;
    logic [KER_W-1:0]  kernel_cols;
    logic [PAD_W-1:0]  pad_rows;
    logic [PAD_W-1:0]  pad_cols;
    logic [STEP_W-1:0] step_rows;
    logic [STEP_W-1:0] step_cols;
  } cfg_t;

  // Decoded column-matrix element at the current walk position
  typedef struct packed {
    logic [CH_IDX_W-1:0] ch;
    logic [DIM_W-1:0]    iy;
    logic [DIM_W-1:0]    ix;
    logic                pad;
    logic                last;
    logic                err;
  } elem_t;

endpackage : im2c_pkg

`default_nettype wire

>>> src/image_to_column_unfold_core.sv
// Top level of the im2col unfold core: stream ports, config registers, sequencer.
// Depends on im2c_pkg, im2c_ram, im2c_mac and im2c_walk.
`timescale 1ns / 1ps
`default_nettype none

// A write beat (tuser = 0) stores one 64-bit word into the image memory. A read
// beat (tuser = 1) returns the next element of the column matrix, walked by
// channel / kernel y / kernel x, then output y, then output x; border positions
// give zero with the padding flag set, the final element has tlast set, and the
// walk then starts over. A read holds off new beats while two passes through the
// shared multiply-add unit build the address ((ch * height + y) * width + x),
// the image memory is read, and the result is loaded into the output register,
// which can hold a result while the next beat is taken; the load waits until
// that register is free. An unusable geometry returns a single beat with the
// error flag and resets the walk; a write to a mapped register also resets it.
// IMAGE_WORDS must be a power of two; addresses wrap modulo IMAGE_WORDS.
module image_to_column_unfold_core #(
  parameter int unsigned IMAGE_WORDS = im2c_pkg::IMAGE_WORDS_DEF,
  parameter int unsigned CHANNELS    = im2c_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [im2c_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [im2c_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [79:0]                       in_tdata,  // [11:0] image_address, [75:12] image_word
  input  wire logic                              in_tuser,  // [0] opcode
  // Output stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [63:0]                       out_tdata, // [63:0] column_value
  output logic                                   out_tlast, // last_element
  output logic      [1:0]                        out_tuser  // [0] is_padding, [1] config_error
);
  import im2c_pkg::*;

  localparam int unsigned AW = $clog2(IMAGE_WORDS);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_READ = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  cfg_t  cfg_r;
  elem_t elem, elem_r;

  logic                in_beat, wr_beat, rd_beat, out_load, cfg_hit;
  logic [ADDR_W-1:0]   in_addr;
  logic [DATA_W-1:0]   in_word;
  logic [MAC_A_W-1:0]  mac_a;
  logic [MAC_B_W-1:0]  mac_b, mac_c;
  logic [MAC_Q_W-1:0]  mac_q;
  logic [DATA_W-1:0]   ram_rdata;

  logic                out_tvalid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_last_r, out_pad_r, out_err_r;

  // Input beat decode
  assign in_tready = (state_r == ST_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign wr_beat   = in_beat && (in_tuser == OP_WRITE);
  assign rd_beat   = in_beat && (in_tuser == OP_READ);
  assign in_addr   = in_tdata[ADDR_W-1:0];
  assign in_word   = in_tdata[ADDR_W+DATA_W-1:ADDR_W];
  assign out_load  = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Configuration registers
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH, REG_KERNEL_ROWS, REG_KERNEL_COLS,
        REG_PAD_ROWS, REG_PAD_COLS, REG_STEP_ROWS, REG_STEP_COLS: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_height <= DIM_W'(8);
      cfg_r.image_width  <= DIM_W'(8);
      cfg_r.kernel_rows  <= KER_W'(3);
      cfg_r.kernel_cols  <= KER_W'(3);
      cfg_r.pad_rows     <= '0;
      cfg_r.pad_cols     <= '0;
      cfg_r.step_rows    <= STEP_W'(1);
      cfg_r.step_cols    <= STEP_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata[DIM_W-1:0];
        REG_KERNEL_ROWS:  cfg_r.kernel_rows  <= cfg_wdata[KER_W-1:0];
        REG_KERNEL_COLS:  cfg_r.kernel_cols  <= cfg_wdata[KER_W-1:0];
        REG_PAD_ROWS:     cfg_r.pad_rows     <= cfg_wdata[PAD_W-1:0];
        REG_PAD_COLS:     cfg_r.pad_cols     <= cfg_wdata[PAD_W-1:0];
        REG_STEP_ROWS:    cfg_r.step_rows    <= cfg_wdata[STEP_W-1:0];
        REG_STEP_COLS:    cfg_r.step_cols    <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Walk counters and element decode
  im2c_walk #(
    .CHANNELS (CHANNELS)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .clear (cfg_hit),
    .step  (rd_beat),
    .elem  (elem)
  );

  // Capture the element taken by a read beat
  always_ff @(posedge clk) begin
    if (rd_beat) begin
      elem_r <= elem;
    end
  end

  // Shared multiply-add: first ch*H + y, then row*W + x
  always_comb begin
    mac_a = MAC_A_W'(elem_r.ch);
    mac_b = cfg_r.image_height;
    mac_c = elem_r.iy;
    if (state_r == ST_MUL2) begin
      mac_a = mac_q[MAC_A_W-1:0];
      mac_b = cfg_r.image_width;
      mac_c = elem_r.ix;
    end
  end

  im2c_mac u_mac (
    .clk (clk),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .q_r (mac_q)
  );

  // Image memory
  im2c_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IMAGE_WORDS)
  ) u_image_ram (
    .clk   (clk),
    .we    (wr_beat),
    .waddr (AW'(in_addr)),
    .wdata (in_word),
    .re    (state_r == ST_READ),
    .raddr (mac_q[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (rd_beat) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= (elem_r.pad || elem_r.err) ? '0 : ram_rdata;
      out_pad_r  <= elem_r.pad && !elem_r.err;
      out_last_r <= elem_r.last && !elem_r.err;
      out_err_r  <= elem_r.err;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_pad_r};

  // Checks
  a_err_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> (out_tdata == '0) && !out_tlast && !out_tuser[0])
    else $error("error beat carries data or flags");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata == '0))
    else $error("padding beat carries nonzero data");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r && (state_r == ST_IDLE))
    else $error("finished element not presented");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rd_beat |=> (state_r == ST_MUL1) && !in_tready)
    else $error("read beat did not start address build");

endmodule : image_to_column_unfold_core

`default_nettype wire

>>> src/im2c_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module im2c_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : im2c_ram

`default_nettype wire

>>> src/im2c_mac.sv
// Shared multiply-add unit used twice per element to form the image address.
// Depends on im2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module im2c_mac (
  input  wire logic                           clk,
  input  wire logic [im2c_pkg::MAC_A_W-1:0]   a,
  input  wire logic [im2c_pkg::MAC_B_W-1:0]   b,
  input  wire logic [im2c_pkg::MAC_B_W-1:0]   c,
  output logic      [im2c_pkg::MAC_Q_W-1:0]   q_r
);
  import im2c_pkg::*;

  logic [MAC_A_W+MAC_B_W-1:0] prod;
  logic [MAC_Q_W-1:0]         q_nxt;

  // One multiply and one add, registered
  assign prod  = a * b;
  assign q_nxt = MAC_Q_W'(prod) + MAC_Q_W'(c);

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule : im2c_mac

`default_nettype wire

>>> src/im2c_walk.sv
// Column-matrix walk: kernel and placement counters, padding, last and error decode.
// Depends on im2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module im2c_walk #(
  parameter int unsigned CHANNELS = im2c_pkg::CHANNELS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire im2c_pkg::cfg_t   cfg,
  input  wire logic             clear,   // write to a mapped register
  input  wire logic             step,    // read beat accepted
  output im2c_pkg::elem_t       elem
);
  import im2c_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  // Kernel position and top-left of the current placement (row * stride)
  logic [KER_W-1:0] kx_r, kx_nxt;
  logic [KER_W-1:0] ky_r, ky_nxt;
  logic [CH_W-1:0]  ch_r, ch_nxt;
  logic [7:0]       xpos_r, xpos_nxt;
  logic [7:0]       ypos_r, ypos_nxt;

  logic [7:0] padded_h, padded_w;
  logic [8:0] iy_raw, ix_raw;
  logic [8:0] row_end, col_end;
  logic       row_last, col_last, k_last;
  logic       err, pad_y, pad_x;

  // Padded image size and usability of the configuration
  assign padded_h = 8'(cfg.image_height) + {3'b0, cfg.pad_rows, 1'b0};
  assign padded_w = 8'(cfg.image_width)  + {3'b0, cfg.pad_cols, 1'b0};

  assign err = (cfg.image_height == '0) || (cfg.image_width == '0) ||
               (cfg.kernel_rows == '0)  || (cfg.kernel_cols == '0) ||
               (cfg.step_rows == '0)    || (cfg.step_cols == '0)   ||
               (8'(cfg.kernel_rows) > padded_h) ||
               (8'(cfg.kernel_cols) > padded_w);

  // Image coordinates before removing the border
  assign iy_raw = 9'(ypos_r) + 9'(ky_r);
  assign ix_raw = 9'(xpos_r) + 9'(kx_r);

  assign pad_y = (iy_raw < 9'(cfg.pad_rows)) ||
                 ((iy_raw - 9'(cfg.pad_rows)) >= 9'(cfg.image_height));
  assign pad_x = (ix_raw < 9'(cfg.pad_cols)) ||
                 ((ix_raw - 9'(cfg.pad_cols)) >= 9'(cfg.image_width));

  // A placement is the last of its row/column when the next one would not fit
  assign row_end  = 9'(ypos_r) + 9'(cfg.step_rows) + 9'(cfg.kernel_rows);
  assign col_end  = 9'(xpos_r) + 9'(cfg.step_cols) + 9'(cfg.kernel_cols);
  assign row_last = row_end > 9'(padded_h);
  assign col_last = col_end > 9'(padded_w);
  assign k_last   = (kx_r == cfg.kernel_cols - 1'b1) &&
                    (ky_r == cfg.kernel_rows - 1'b1) && (ch_r == CH_LAST);

  always_comb begin
    elem.ch   = CH_IDX_W'(ch_r);
    elem.iy   = DIM_W'(iy_raw - 9'(cfg.pad_rows));
    elem.ix   = DIM_W'(ix_raw - 9'(cfg.pad_cols));
    elem.pad  = pad_y || pad_x;
    elem.last = k_last && row_last && col_last;
    elem.err  = err;
  end

  // Advance: output x, then output y, then kernel x, kernel y, channel
  always_comb begin
    kx_nxt   = kx_r;
    ky_nxt   = ky_r;
    ch_nxt   = ch_r;
    xpos_nxt = xpos_r;
    ypos_nxt = ypos_r;
    if (err || elem.last) begin
      kx_nxt   = '0;
      ky_nxt   = '0;
      ch_nxt   = '0;
      xpos_nxt = '0;
      ypos_nxt = '0;
    end else if (!col_last) begin
      xpos_nxt = 8'(9'(xpos_r) + 9'(cfg.step_cols));
    end else begin
      xpos_nxt = '0;
      if (!row_last) begin
        ypos_nxt = 8'(9'(ypos_r) + 9'(cfg.step_rows));
      end else begin
        ypos_nxt = '0;
        if (kx_r != cfg.kernel_cols - 1'b1) begin
          kx_nxt = kx_r + 1'b1;
        end else begin
          kx_nxt = '0;
          if (ky_r != cfg.kernel_rows - 1'b1) begin
            ky_nxt = ky_r + 1'b1;
          end else begin
            ky_nxt = '0;
            ch_nxt = (ch_r == CH_LAST) ? '0 : ch_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      kx_r   <= '0;
      ky_r   <= '0;
      ch_r   <= '0;
      xpos_r <= '0;
      ypos_r <= '0;
    end else if (step) begin
      kx_r   <= kx_nxt;
      ky_r   <= ky_nxt;
      ch_r   <= ch_nxt;
      xpos_r <= xpos_nxt;
      ypos_r <= ypos_nxt;
    end
  end

endmodule : im2c_walk

`default_nettype wire

>>> dv/tb_image_to_column_unfold_core.sv
// Testbench for image_to_column_unfold_core: a directed stimulus table, then random
// write and read beats; results are checked against table entries or a bench walk model.
// Depends on im2c_pkg and image_to_column_unfold_core.
`timescale 1ns / 1ps

module tb_image_to_column_unfold_core;
  import im2c_pkg::*;

  localparam int unsigned MEM_WORDS     = IMAGE_WORDS_DEF;
  localparam int unsigned N_CHANNELS    = CHANNELS_DEF;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned RANDOM_BEATS  = 430;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

  // One result beat as the model sees it
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              pad;
    logic              last;
    logic              err;
  } col_elem_t;

  localparam col_elem_t NO_RESULT = '0;

  // One row of the directed table: a register write or a stream beat
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    logic                  op;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     word;
    bit                    typed;
    col_elem_t             res;
  } plan_row_t;

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [79:0]           in_tdata = '0;   // [11:0] image_address, [75:12] image_word
  logic                  in_tuser = 1'b0; // [0] opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [63:0]           out_tdata;       // [63:0] column_value
  logic                  out_tlast;       // last_element
  logic [1:0]            out_tuser;       // [0] is_padding, [1] config_error

  // Walk model state
  cfg_t              geom;
  logic [10:0]       krow_cnt;
  logic [6:0]        orow_cnt;
  logic [6:0]        ocol_cnt;
  logic [DATA_W-1:0] img_mem [MEM_WORDS];
  bit                img_written [MEM_WORDS];

  // Current element, filled in by locate_element
  bit                elem_err;
  bit                elem_in_image;
  bit                elem_last;
  logic [ADDR_W-1:0] elem_addr;
  int unsigned       walk_rows;
  int unsigned       walk_cols;
  int unsigned       walk_kernels;

  col_elem_t   col_expect [$];
  plan_row_t   plan [$];
  bit          row_typed = 1'b0;
  col_elem_t   row_res = '0;
  int unsigned mismatch_count = 0;
  int unsigned beats_sent = 0;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 80;
  int unsigned stall_cycles = 0;
  int unsigned reg_w [NUM_REGS] = '{DIM_W, DIM_W, KER_W, KER_W, PAD_W, PAD_W, STEP_W, STEP_W};

  image_to_column_unfold_core #(
    .IMAGE_WORDS (MEM_WORDS),
    .CHANNELS    (N_CHANNELS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic void clear_walk();
    krow_cnt = '0;
    orow_cnt = '0;
    ocol_cnt = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_HEIGHT: geom.image_height = val[DIM_W-1:0];
      REG_IMAGE_WIDTH:  geom.image_width  = val[DIM_W-1:0];
      REG_KERNEL_ROWS:  geom.kernel_rows  = val[KER_W-1:0];
      REG_KERNEL_COLS:  geom.kernel_cols  = val[KER_W-1:0];
      REG_PAD_ROWS:     geom.pad_rows     = val[PAD_W-1:0];
      REG_PAD_COLS:     geom.pad_cols     = val[PAD_W-1:0];
      REG_STEP_ROWS:    geom.step_rows    = val[STEP_W-1:0];
      REG_STEP_COLS:    geom.step_cols    = val[STEP_W-1:0];
      default: return;
    endcase
    clear_walk();
  endfunction

  // Decode the walk position into an image position without advancing it
  function automatic void locate_element();
    int unsigned h, w, kr, kc, pr, pc, sr, sc, ph, pw, kx, ky, ch, kcnt;
    int iy, ix;
    h  = geom.image_height;
    w  = geom.image_width;
    kr = geom.kernel_rows;
    kc = geom.kernel_cols;
    pr = geom.pad_rows;
    pc = geom.pad_cols;
    sr = geom.step_rows;
    sc = geom.step_cols;
    ph = h + 2 * pr;
    pw = w + 2 * pc;
    elem_err = (h == 0) || (w == 0) || (kr == 0) || (kc == 0) || (sr == 0) ||
               (sc == 0) || (kr > ph) || (kc > pw);
    elem_in_image = 1'b0;
    elem_last = 1'b0;
    elem_addr = '0;
    if (elem_err) return;
    walk_rows    = (ph - kr) / sr + 1;
    walk_cols    = (pw - kc) / sc + 1;
    walk_kernels = N_CHANNELS * kr * kc;
    kcnt = krow_cnt;
    kx = kcnt % kc;
    ky = (kcnt / kc) % kr;
    ch = kcnt / (kr * kc);
    iy = int'(orow_cnt * sr + ky) - int'(pr);
    ix = int'(ocol_cnt * sc + kx) - int'(pc);
    elem_in_image = (iy >= 0) && (iy < int'(h)) && (ix >= 0) && (ix < int'(w));
    if (elem_in_image)
      elem_addr = ADDR_W'(((ch * h + unsigned'(iy)) * w + unsigned'(ix)) % MEM_WORDS);
    elem_last = (kcnt + 1 >= walk_kernels) && (orow_cnt + 1 >= walk_rows) &&
                (ocol_cnt + 1 >= walk_cols);
  endfunction

  // Apply one accepted beat; returns 1 when it yields a result beat
  function automatic bit predict_beat(input logic op, input logic [79:0] data,
                                      output col_elem_t res);
    int unsigned nxt_col, nxt_row, nxt_k;
    res = '0;
    if (op == OP_WRITE) begin
      img_mem[data[ADDR_W-1:0]] = data[ADDR_W+DATA_W-1:ADDR_W];
      img_written[data[ADDR_W-1:0]] = 1'b1;
      return 1'b0;
    end
    locate_element();
    if (elem_err) begin
      clear_walk();
      res.err = 1'b1;
      return 1'b1;
    end
    if (elem_in_image) res.value = img_mem[elem_addr];
    else res.pad = 1'b1;
    res.last = elem_last;
    if (elem_last) begin
      clear_walk();
      return 1'b1;
    end
    // x fastest, then y, then kernel row
    nxt_col = ocol_cnt + 1;
    nxt_row = orow_cnt;
    nxt_k   = krow_cnt;
    if (nxt_col >= walk_cols) begin
      nxt_col = 0;
      nxt_row++;
      if (nxt_row >= walk_rows) begin
        nxt_row = 0;
        nxt_k++;
        if (nxt_k >= walk_kernels) nxt_k = 0;
      end
    end
    ocol_cnt = nxt_col[6:0];
    orow_cnt = nxt_row[6:0];
    krow_cnt = nxt_k[10:0];
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input col_elem_t want,
                                        input col_elem_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("%0t: %s: expected value=%h pad=%b last=%b err=%b, got value=%h pad=%b last=%b err=%b",
               $time, what, want.value, want.pad, want.last, want.err,
               got.value, got.pad, got.last, got.err);
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.cfg_val = val;
    plan.push_back(row);
  endfunction

  function automatic void add_beat(input logic op, input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] word, input bit typed,
                                   input col_elem_t res);
    plan_row_t row;
    row = '{default: '0};
    row.op = op;
    row.addr = addr;
    row.word = word;
    row.typed = typed;
    row.res = res;
    plan.push_back(row);
  endfunction

  // Register write, only while nothing is in flight
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid = 1'b0;
    while (col_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drive one input beat and hold it until accepted
  task automatic send_beat(input logic op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] word, input bit typed,
                           input col_elem_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser = op;
    in_tdata = {4'b0, word, addr};
    row_typed = typed;
    row_res = res;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    beats_sent++;
    if (beats_sent >= 300) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (beats_sent >= 150) begin
      send_idle_pct = 80;
      recv_idle_pct = 38;
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_idle_pct);

  // Monitor: register writes, result check, input prediction
  always @(posedge clk) begin
    col_elem_t got, want, pred;
    if (rst_n && cfg_we) apply_reg(cfg_index, cfg_wdata);
    if (rst_n && out_tvalid && out_tready) begin
      got = '{value: out_tdata, pad: out_tuser[0], last: out_tlast, err: out_tuser[1]};
      if (col_expect.size() == 0) begin
        note_mismatch("result beat with none expected", NO_RESULT, got);
      end else begin
        want = col_expect.pop_front();
        if (got.value !== want.value || got.pad !== want.pad ||
            got.last !== want.last || got.err !== want.err)
          note_mismatch("result beat differs", want, got);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      if (predict_beat(in_tuser, in_tdata, pred))
        col_expect.push_back(row_typed ? row_res : pred);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("image_to_column_unfold_core: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned directed_beats;
    int unsigned geo [NUM_REGS];
    geom = '{image_height: 7'd8, image_width: 7'd8, kernel_rows: 5'd3, kernel_cols: 5'd3,
             pad_rows: 4'd0, pad_cols: 4'd0, step_rows: 5'd1, step_cols: 5'd1};
    clear_walk();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset geometry, error geometries, 1x1 image walk with wrap,
    // full padding, largest kernel and stride, ignored register index
    add_beat(OP_WRITE, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_RESULT);
    add_beat(OP_READ, '0, '0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0});
    add_beat(OP_WRITE, 12'd1, 64'h0, 1'b0, NO_RESULT);
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0, 1'b0, 1'b0, 1'b0});
    add_cfg(REG_IMAGE_HEIGHT, 7'd0);
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0, 1'b0, 1'b0, 1'b1});
    add_cfg(REG_IMAGE_HEIGHT, 7'd1);
    add_cfg(REG_IMAGE_WIDTH, 7'd1);
    add_cfg(REG_KERNEL_ROWS, 7'd1);
    add_cfg(REG_KERNEL_COLS, 7'd1);
    add_beat(OP_WRITE, 12'd2, 64'h8000_0000_0000_0001, 1'b0, NO_RESULT);
    add_beat(OP_WRITE, 12'd3, 64'h0123_4567_89AB_CDEF, 1'b0, NO_RESULT);
    // one element per channel, last on channel 3, then back to channel 0
    add_beat(OP_READ, '1, '1, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0});
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0, 1'b0, 1'b0, 1'b0});
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 1'b0});
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0123_4567_89AB_CDEF, 1'b0, 1'b1, 1'b0});
    add_beat(OP_READ, '0, '0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0});
    // kernel taller than the unpadded 1x1 image
    add_cfg(REG_KERNEL_ROWS, 7'd2);
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0, 1'b0, 1'b0, 1'b1});
    add_cfg(REG_PAD_ROWS, 7'd15);
    add_cfg(REG_PAD_COLS, 7'd15);
    add_cfg(REG_KERNEL_ROWS, 7'd16);
    add_cfg(REG_KERNEL_COLS, 7'd16);
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0, 1'b1, 1'b0, 1'b0});
    add_cfg(REG_STEP_ROWS, 7'd16);
    add_cfg(REG_STEP_COLS, 7'd16);
    add_beat(OP_READ, '0, '0, 1'b1, '{64'h0, 1'b1, 1'b0, 1'b0});
    // write to an unmapped index must not restart the walk
    add_cfg(REG_FIRST_UNUSED, 7'h7F);
    add_beat(OP_READ, '0, '0, 1'b0, NO_RESULT);
    add_beat(OP_WRITE, 12'hFFF, 64'h0, 1'b0, NO_RESULT);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_reg(plan[i].idx, plan[i].cfg_val);
      else send_beat(plan[i].op, plan[i].addr, plan[i].word, plan[i].typed, plan[i].res);
    end
    directed_beats = beats_sent;

    // Random phases: new geometry, then mostly well-formed read walks
    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      geo[REG_IMAGE_HEIGHT] = $urandom_range(1, 3);
      geo[REG_IMAGE_WIDTH]  = $urandom_range(1, 3);
      geo[REG_KERNEL_ROWS]  = $urandom_range(1, 2);
      geo[REG_KERNEL_COLS]  = $urandom_range(1, 2);
      geo[REG_PAD_ROWS]     = $urandom_range(0, 1);
      geo[REG_PAD_COLS]     = $urandom_range(0, 1);
      geo[REG_STEP_ROWS]    = $urandom_range(1, 2);
      geo[REG_STEP_COLS]    = $urandom_range(1, 2);
      case ($urandom_range(11))
        0: begin
          // largest image, kernel, padding and stride
          geo[REG_IMAGE_HEIGHT] = 64;
          geo[REG_IMAGE_WIDTH]  = 64;
          geo[REG_KERNEL_ROWS]  = 16;
          geo[REG_KERNEL_COLS]  = 16;
          geo[REG_PAD_ROWS]     = 15;
          geo[REG_PAD_COLS]     = 15;
          geo[REG_STEP_ROWS]    = 16;
          geo[REG_STEP_COLS]    = 16;
        end
        1: begin
          // full image, 1x1 kernel: channel addresses wrap the memory
          geo[REG_IMAGE_HEIGHT] = 64;
          geo[REG_IMAGE_WIDTH]  = 64;
          geo[REG_KERNEL_ROWS]  = 1;
          geo[REG_KERNEL_COLS]  = 1;
          geo[REG_PAD_ROWS]     = $urandom_range(0, 15);
          geo[REG_PAD_COLS]     = $urandom_range(0, 15);
          geo[REG_STEP_ROWS]    = $urandom_range(1, 16);
          geo[REG_STEP_COLS]    = $urandom_range(1, 16);
        end
        2: begin
          // unusable geometry
          case ($urandom_range(7))
            0: geo[REG_IMAGE_HEIGHT] = 0;
            1: geo[REG_IMAGE_WIDTH]  = 0;
            2: geo[REG_KERNEL_ROWS]  = 0;
            3: geo[REG_KERNEL_COLS]  = 0;
            4: geo[REG_STEP_ROWS]    = 0;
            5: geo[REG_STEP_COLS]    = 0;
            6: geo[REG_KERNEL_ROWS]  = geo[REG_IMAGE_HEIGHT] + 2 * geo[REG_PAD_ROWS] + 1;
            default: geo[REG_KERNEL_COLS] = geo[REG_IMAGE_WIDTH] + 2 * geo[REG_PAD_COLS] + 1;
          endcase
        end
        3: begin
          // beyond the documented ranges, used as written
          geo[REG_IMAGE_HEIGHT] = $urandom_range(65, 100);
          geo[REG_IMAGE_WIDTH]  = $urandom_range(65, 100);
          geo[REG_KERNEL_ROWS]  = 16;
          geo[REG_KERNEL_COLS]  = 16;
          geo[REG_PAD_ROWS]     = $urandom_range(0, 3);
          geo[REG_PAD_COLS]     = $urandom_range(0, 3);
          geo[REG_STEP_ROWS]    = $urandom_range(17, 31);
          geo[REG_STEP_COLS]    = $urandom_range(17, 31);
        end
        default: ;
      endcase
      // spare upper bits of the narrow registers carry noise
      for (int r = 0; r < NUM_REGS; r++)
        set_reg(CFG_IDX_W'(r), CFG_DATA_W'(geo[r] | ($urandom << reg_w[r])));
      if ($urandom_range(9) == 0)
        set_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(7)), CFG_DATA_W'($urandom));

      repeat ($urandom_range(8, 60)) begin
        if (beats_sent >= directed_beats + RANDOM_BEATS) break;
        if ($urandom_range(99) < 15) begin
          send_beat(OP_WRITE, ADDR_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RESULT);
        end else begin
          // fill the word the next read will fetch if it was never written
          locate_element();
          if (!elem_err && elem_in_image && !img_written[elem_addr])
            send_beat(OP_WRITE, elem_addr, {$urandom, $urandom}, 1'b0, NO_RESULT);
          send_beat(OP_READ, ADDR_W'($urandom), {$urandom, $urandom}, 1'b0, NO_RESULT);
        end
      end
    end

    // Drain
    in_tvalid = 1'b0;
    while (col_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("image_to_column_unfold_core: match");
    end else begin
      $display("image_to_column_unfold_core: mismatch");
    end
    $finish;
  end

endmodule

>>> image_to_column_unfold_core.f
src/im2c_pkg.sv
src/im2c_ram.sv
src/im2c_mac.sv
src/im2c_walk.sv
src/image_to_column_unfold_core.sv
dv/tb_image_to_column_unfold_core.sv
